### design/bgpt_pkg.sv
`default_nettype none

package bgpt_pkg;

	// Gait phase codes. Codes 6 and 7 are never produced.
	typedef enum logic [2:0] {
		PH_UNKNOWN = 3'd0,
		PH_EARLY   = 3'd1,
		PH_LATE    = 3'd2,
		PH_LIFTOFF = 3'd3,
		PH_SWING   = 3'd4,
		PH_LANDING = 3'd5
	} phase_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_STANCE_LOAD_LIMIT = 3'd0,
		REG_SWING_LOAD_LIMIT  = 3'd1,
		REG_LANDING_RATIO     = 3'd2,
		REG_LATE_STANCE_RATIO = 3'd3,
		REG_LIFTOFF_RATIO     = 3'd4,
		REG_LEFT_LEG_LENGTH   = 3'd5,
		REG_RIGHT_LEG_LENGTH  = 3'd6
	} reg_index_t;

	localparam int LOAD_W  = 16;
	localparam int POS_W   = 16;
	localparam int LIMIT_W = 15;
	localparam int RATIO_W = 14;
	localparam int LEN_W   = 14;
	localparam int CFG_W   = 15;

	// Threshold test results and position of one leg.
	typedef struct packed {
		logic               stance;
		logic               swing;
		logic               late;
		logic               liftoff;
		logic               landing;
		logic [POS_W-1:0]   pos;
	} leg_view_t;

	// Limits and ratios shared by both legs.
	typedef struct packed {
		logic [LIMIT_W-1:0] stance_limit;
		logic [LIMIT_W-1:0] swing_limit;
		logic [RATIO_W-1:0] landing_ratio;
		logic [RATIO_W-1:0] late_ratio;
		logic [RATIO_W-1:0] liftoff_ratio;
	} thresholds_t;

endpackage

`default_nettype wire

### design/bgpt_leg_eval.sv
`default_nettype none

module bgpt_leg_eval import bgpt_pkg::*; #(
	parameter int FRAC_BITS = 12
) (
	input  wire logic [LOAD_W-1:0] load,
	input  wire logic [POS_W-1:0]  pos,
	input  wire logic [LEN_W-1:0]  len,
	input  wire thresholds_t       thr,
	output leg_view_t              view
);

	// Length times ratio is exact in PROD_W bits; the compare width also covers
	// the position shifted up by the fraction bits.
	localparam int PROD_W = LEN_W + RATIO_W + 1;
	localparam int SCL_W  = POS_W + FRAC_BITS;
	localparam int CMP_W  = ((SCL_W > PROD_W) ? SCL_W : PROD_W) + 1;

	logic signed [LEN_W:0]       len_s;
	logic signed [PROD_W-1:0]    late_prod;
	logic signed [PROD_W-1:0]    liftoff_prod;
	logic signed [PROD_W-1:0]    landing_prod;
	logic signed [CMP_W-1:0]     scaled;
	logic signed [LOAD_W:0]      load_x;
	logic signed [LOAD_W:0]      stance_x;
	logic signed [LOAD_W:0]      swing_x;

	assign len_s        = $signed({1'b0, len});
	assign late_prod    = len_s * $signed(thr.late_ratio);
	assign liftoff_prod = len_s * $signed(thr.liftoff_ratio);
	assign landing_prod = len_s * $signed(thr.landing_ratio);

	assign scaled = CMP_W'($signed(pos)) <<< FRAC_BITS;

	assign load_x   = (LOAD_W + 1)'($signed(load));
	assign stance_x = $signed({2'b00, thr.stance_limit});
	assign swing_x  = $signed({2'b00, thr.swing_limit});

	always_comb begin
		view.stance  = load_x > stance_x;
		view.swing   = load_x <= swing_x;
		view.late    = scaled < CMP_W'(late_prod);
		view.liftoff = scaled < CMP_W'(liftoff_prod);
		view.landing = scaled > CMP_W'(landing_prod);
		view.pos     = pos;
	end

endmodule

`default_nettype wire

### design/bgpt_phase_next.sv
`default_nettype none

module bgpt_phase_next import bgpt_pkg::*; (
	input  wire phase_t    cur,
	input  wire leg_view_t me,
	input  wire leg_view_t other,
	output phase_t         nxt
);

	logic other_leads;
	logic me_ahead;

	// The other leg is planted in front of this one.
	assign other_leads = other.stance && ($signed(me.pos) < $signed(other.pos));
	assign me_ahead    = $signed(me.pos) > $signed(other.pos);

	always_comb begin
		nxt = cur;
		case (cur)
			PH_UNKNOWN: begin
				if (me.stance) begin
					if (other_leads) nxt = PH_LIFTOFF;
					else if (me.late) nxt = PH_LATE;
					else nxt = PH_EARLY;
				end else begin
					nxt = me.landing ? PH_LANDING : PH_SWING;
				end
			end
			PH_EARLY: begin
				if (other_leads) nxt = PH_LIFTOFF;
				else if (me.late) nxt = PH_LATE;
			end
			PH_LATE: begin
				if (other_leads || me.liftoff) nxt = PH_LIFTOFF;
			end
			PH_LIFTOFF: begin
				if (me.swing) nxt = PH_SWING;
			end
			PH_SWING: begin
				if (me.stance && me_ahead) nxt = PH_EARLY;
				else if (!me.stance && me.landing) nxt = PH_LANDING;
			end
			PH_LANDING: begin
				if (me.stance) nxt = PH_EARLY;
			end
			default: nxt = cur;
		endcase
	end

endmodule

`default_nettype wire

### design/biped_gait_phase_tracker_unit.sv
// Biped gait phase tracker. Each input word carries both legs' load and
// foot-minus-hip position plus a step flag; each word yields exactly one
// output word with both leg phases and their change flags. A word is
// registered on entry, evaluated combinationally by the threshold
// multipliers and phase logic, and its result registered on the way out.
// One word is taken every cycle unless the output stalls; the phase
// registers close a loop between consecutive words. Output stall holds the
// result register and backs up into the input register. Configuration
// writes take effect at once; the user makes them only while idle (unenforced).
`default_nettype none

module biped_gait_phase_tracker_unit import bgpt_pkg::*; #(
	parameter int FRAC_BITS = 12
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              step_advanced,
	input  wire logic [LOAD_W-1:0] left_load,
	input  wire logic [LOAD_W-1:0] right_load,
	input  wire logic [POS_W-1:0]  left_forward_pos,
	input  wire logic [POS_W-1:0]  right_forward_pos,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [2:0]             left_phase,
	output logic [2:0]             right_phase,
	output logic                   left_changed,
	output logic                   right_changed,
	input  wire logic              wr_en,
	input  wire logic [2:0]        wr_index,
	input  wire logic [CFG_W-1:0]  wr_data
);

	thresholds_t        thr_q;
	logic [LEN_W-1:0]   left_len_q;
	logic [LEN_W-1:0]   right_len_q;

	logic               valid_s1;
	logic               step_s1;
	logic [LOAD_W-1:0]  left_load_s1;
	logic [LOAD_W-1:0]  right_load_s1;
	logic [POS_W-1:0]   left_pos_s1;
	logic [POS_W-1:0]   right_pos_s1;

	logic               valid_s2;
	logic               left_changed_s2;
	logic               right_changed_s2;
	phase_t             left_phase_q;
	phase_t             right_phase_q;

	leg_view_t          left_view;
	leg_view_t          right_view;
	phase_t             left_next;
	phase_t             right_next;
	logic               accept;
	logic               advance;

	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.stance_limit  <= LIMIT_W'(410);
			thr_q.swing_limit   <= LIMIT_W'(410);
			thr_q.landing_ratio <= '0;
			thr_q.late_ratio    <= '0;
			thr_q.liftoff_ratio <= RATIO_W'(-4096);
			left_len_q          <= LEN_W'(4096);
			right_len_q         <= LEN_W'(4096);
		end else if (wr_en) begin
			case (reg_index_t'(wr_index))
				REG_STANCE_LOAD_LIMIT: thr_q.stance_limit  <= wr_data;
				REG_SWING_LOAD_LIMIT:  thr_q.swing_limit   <= wr_data;
				REG_LANDING_RATIO:     thr_q.landing_ratio <= wr_data[RATIO_W-1:0];
				REG_LATE_STANCE_RATIO: thr_q.late_ratio    <= wr_data[RATIO_W-1:0];
				REG_LIFTOFF_RATIO:     thr_q.liftoff_ratio <= wr_data[RATIO_W-1:0];
				REG_LEFT_LEG_LENGTH:   left_len_q          <= wr_data[LEN_W-1:0];
				REG_RIGHT_LEG_LENGTH:  right_len_q         <= wr_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			step_s1       <= step_advanced;
			left_load_s1  <= left_load;
			right_load_s1 <= right_load;
			left_pos_s1   <= left_forward_pos;
			right_pos_s1  <= right_forward_pos;
		end
	end

	bgpt_leg_eval #(.FRAC_BITS(FRAC_BITS)) u_left_eval (
		.load (left_load_s1),
		.pos  (left_pos_s1),
		.len  (left_len_q),
		.thr  (thr_q),
		.view (left_view)
	);

	bgpt_leg_eval #(.FRAC_BITS(FRAC_BITS)) u_right_eval (
		.load (right_load_s1),
		.pos  (right_pos_s1),
		.len  (right_len_q),
		.thr  (thr_q),
		.view (right_view)
	);

	bgpt_phase_next u_left_next (
		.cur   (left_phase_q),
		.me    (left_view),
		.other (right_view),
		.nxt   (left_next)
	);

	bgpt_phase_next u_right_next (
		.cur   (right_phase_q),
		.me    (right_view),
		.other (left_view),
		.nxt   (right_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1         <= 1'b0;
			valid_s2         <= 1'b0;
			left_phase_q     <= PH_UNKNOWN;
			right_phase_q    <= PH_UNKNOWN;
			left_changed_s2  <= 1'b0;
			right_changed_s2 <= 1'b0;
		end else begin
			valid_s1 <= accept || in_stall;
			valid_s2 <= advance || (valid_s2 && out_stall);
			if (advance) begin
				// A hold word repeats the current phases with no change flagged.
				if (step_s1) begin
					left_phase_q  <= left_next;
					right_phase_q <= right_next;
				end
				left_changed_s2  <= step_s1 && (left_next != left_phase_q);
				right_changed_s2 <= step_s1 && (right_next != right_phase_q);
			end
		end
	end

	// The phase registers only move with a new result, so they double as the
	// output phase fields.
	assign out_valid     = valid_s2;
	assign left_phase    = left_phase_q;
	assign right_phase   = right_phase_q;
	assign left_changed  = left_changed_s2;
	assign right_changed = right_changed_s2;

endmodule

`default_nettype wire
